### rtl/sm3_pkg.sv
// SM3 engine package: payload structs, controller/datapath command types,
// FSM state enum and round helper functions. No dependencies.
`default_nettype none
package sm3_pkg;

  localparam int unsigned NumIv = 8;
  localparam logic [31:0] TLow  = 32'h79CC4519;
  localparam logic [31:0] THigh = 32'h7A879D8A;
  localparam logic [31:0] PadByte = 32'h00000080;
  localparam logic [255:0] IvReset = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } out_word_t;

  // Source of the word written into the block buffer.
  typedef enum logic [1:0] {
    WsrcMsg,
    WsrcPad,
    WsrcZero,
    WsrcLen
  } wsrc_e;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StRound,
    StFold,
    StOut
  } state_e;

  typedef struct packed {
    logic        take;      // an input word is accepted
    logic        push;      // write a word into the block buffer
    wsrc_e       wsrc;
    logic        len_hi;    // length word: upper half
    logic        start_msg; // load chaining value from IV
    logic        init_blk;  // copy chaining value into working vars
    logic        round;     // perform one round
    logic        fold;      // xor working vars into chaining value
    logic        clr_msg;   // clear length and index
    logic        out_shift; // next digest word
  } cmd_t;

  typedef struct packed {
    logic [3:0] word_index;
    logic [5:0] round_index;
    logic       round_last;
    logic       started;
  } status_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

### rtl/sm3_ctrl.sv
// SM3 controller: sequences word intake, padding, rounds and digest output.
// Depends on sm3_pkg.
`default_nettype none
module sm3_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sm3_pkg::in_word_t in_data_i,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire sm3_pkg::status_t  status_i,
  output sm3_pkg::cmd_t          cmd_o
);
  import sm3_pkg::*;

  state_e state_q, state_d;
  state_e ret_q, ret_d;      // where to go after a block finishes
  logic [1:0] pad_q, pad_d;  // 0: pad word, 1: zeros, 2: len hi, 3: len lo
  logic [2:0] cnt_q, cnt_d;
  logic       full4_q, full4_d;

  logic accept;
  logic wrap;
  assign accept = in_valid && !in_stall;
  assign wrap   = cmd_o.push && (status_i.word_index == 4'd15);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    pad_d   = pad_q;
    cnt_d   = cnt_q;
    full4_d = full4_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_data_i.end_of_message) begin
            full4_d = (in_data_i.byte_count >= 3'd4);
            pad_d   = 2'd0;
            ret_d   = StPad;
            state_d = (full4_d && wrap) ? StRound : StPad;
          end else if (wrap) begin
            ret_d   = StIdle;
            state_d = StRound;
          end
        end
      end
      StPad: begin
        unique case (pad_q)
          2'd0: pad_d = (status_i.word_index == 4'd13) ? 2'd2 : 2'd1;
          2'd1: pad_d = (status_i.word_index == 4'd13) ? 2'd2 : 2'd1;
          2'd2: pad_d = 2'd3;
          default: pad_d = 2'd3;
        endcase
        if (pad_q == 2'd3) begin
          ret_d = StOut;
        end else begin
          ret_d = StPad;
        end
        if (wrap) state_d = StRound;
        if (pad_q == 2'd0 && status_i.word_index == 4'd15) pad_d = 2'd1;
      end
      StRound: if (status_i.round_last) state_d = StFold;
      StFold: begin
        state_d = ret_q;
        cnt_d   = 3'd0;
      end
      StOut: begin
        if (!out_stall) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd7) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.wsrc = WsrcMsg;
    in_stall  = (state_q != StIdle);
    out_valid = (state_q == StOut);
    unique case (state_q)
      StIdle: begin
        if (in_valid) begin
          cmd_o.take = 1'b1;
          cmd_o.start_msg = !status_i.started;
          cmd_o.push = !in_data_i.end_of_message || (in_data_i.byte_count >= 3'd4);
          cmd_o.init_blk = cmd_o.push && (status_i.word_index == 4'd15);
        end
      end
      StPad: begin
        cmd_o.push = 1'b1;
        unique case (pad_q)
          2'd0: cmd_o.wsrc = WsrcPad;
          2'd1: cmd_o.wsrc = WsrcZero;
          2'd2: begin cmd_o.wsrc = WsrcLen; cmd_o.len_hi = 1'b1; end
          default: cmd_o.wsrc = WsrcLen;
        endcase
        cmd_o.init_blk = (status_i.word_index == 4'd15);
      end
      StRound: cmd_o.round = 1'b1;
      StFold: begin
        cmd_o.fold = 1'b1;
        cmd_o.clr_msg = (ret_q == StOut);
      end
      StOut: cmd_o.out_shift = !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      pad_q   <= 2'd0;
      cnt_q   <= 3'd0;
      full4_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pad_q   <= pad_d;
      cnt_q   <= cnt_d;
      full4_q <= full4_d;
    end
  end

endmodule
`default_nettype wire

### rtl/sm3_datapath.sv
// SM3 datapath: block buffer, message expansion, round logic, chaining value,
// bit length and digest shift register. Depends on sm3_pkg.
`default_nettype none
module sm3_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [255:0]       iv_i,
  input  wire sm3_pkg::in_word_t  in_data_i,
  input  wire sm3_pkg::cmd_t      cmd_i,
  output sm3_pkg::status_t        status_o,
  output sm3_pkg::out_word_t      out_data_o
);
  import sm3_pkg::*;

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] cv_q [8];
  logic [31:0] dig_q [8];
  logic [3:0]  widx_q;
  logic [5:0]  ridx_q;
  logic [2:0]  oidx_q;
  logic [63:0] len_q;
  logic        started_q;
  logic [31:0] pad_word_q;

  logic [2:0]  bc;
  logic [31:0] pad_word, wdata, wj, wj1, wnew, t, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic [31:0] cv_sel [8];
  logic [63:0] len_add;

  assign bc = (in_data_i.byte_count > 3'd4) ? 3'd4 : in_data_i.byte_count;

  always_comb begin
    unique case (bc)
      3'd0: pad_word = 32'h80000000;
      3'd1: pad_word = {in_data_i.message_word[31:24], 24'h800000};
      3'd2: pad_word = {in_data_i.message_word[31:16], 16'h8000};
      3'd3: pad_word = {in_data_i.message_word[31:8], 8'h80};
      default: pad_word = {PadByte[7:0], 24'h0};
    endcase
  end

  always_comb begin
    if (!in_data_i.end_of_message) len_add = len_q + 64'd32;
    else len_add = len_q + {58'd0, bc, 3'd0};
  end

  always_comb begin
    unique case (cmd_i.wsrc)
      WsrcMsg:  wdata = in_data_i.message_word;
      WsrcPad:  wdata = pad_word_q;
      WsrcZero: wdata = 32'd0;
      default:  wdata = cmd_i.len_hi ? len_q[63:32] : len_q[31:0];
    endcase
  end

  for (genvar i = 0; i < 8; i++) begin : g_cv
    assign cv_sel[i] = (cmd_i.start_msg) ? iv_i[255-32*i -: 32] : cv_q[i];
  end

  // The window is kept shifted: w_q[0] is W[j] of the current round.
  assign wj   = w_q[0];
  assign wj1  = w_q[0] ^ w_q[4];
  assign wnew = p1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
  assign t    = (ridx_q < 6'd16) ? TLow : THigh;
  assign a12  = rotl(v_q[0], 5'd12);
  assign ss1  = rotl(a12 + v_q[4] + rotl(t, ridx_q[4:0]), 5'd7);
  assign ss2  = ss1 ^ a12;
  always_comb begin
    if (ridx_q < 6'd16) begin
      ff = v_q[0] ^ v_q[1] ^ v_q[2];
      gg = v_q[4] ^ v_q[5] ^ v_q[6];
    end else begin
      ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
      gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
    end
  end
  assign tt1 = ff + v_q[3] + ss2 + wj1;
  assign tt2 = gg + v_q[7] + ss1 + wj;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) w_q[widx_q] <= wdata;
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
    if (cmd_i.take && in_data_i.end_of_message) begin
      pad_word_q <= pad_word;
    end
    if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) dig_q[i] <= cv_q[i] ^ v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i]  <= '0;
        cv_q[i] <= IvReset[255-32*i -: 32];
      end
      widx_q <= '0;
      ridx_q <= '0;
      oidx_q <= '0;
      len_q <= '0;
      started_q <= 1'b0;
    end else begin
      if (cmd_i.start_msg) begin
        started_q <= 1'b1;
        for (int i = 0; i < 8; i++) cv_q[i] <= cv_sel[i];
      end
      if (cmd_i.take) len_q <= len_add;
      if (cmd_i.push) widx_q <= widx_q + 4'd1;
      if (cmd_i.init_blk) begin
        for (int i = 0; i < 8; i++) v_q[i] <= cv_sel[i];
        ridx_q <= '0;
      end
      if (cmd_i.round) begin
        v_q[3] <= v_q[2];
        v_q[2] <= rotl(v_q[1], 5'd9);
        v_q[1] <= v_q[0];
        v_q[0] <= tt1;
        v_q[7] <= v_q[6];
        v_q[6] <= rotl(v_q[5], 5'd19);
        v_q[5] <= v_q[4];
        v_q[4] <= p0(tt2);
        ridx_q <= ridx_q + 6'd1;
      end
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ v_q[i];
        oidx_q <= '0;
      end
      if (cmd_i.clr_msg) begin
        len_q <= '0;
        widx_q <= '0;
        started_q <= 1'b0;
      end
      if (cmd_i.out_shift) oidx_q <= oidx_q + 3'd1;
    end
  end

  assign status_o.word_index  = widx_q;
  assign status_o.round_index = ridx_q;
  assign status_o.round_last  = (ridx_q == 6'd63);
  assign status_o.started     = started_q;
  assign out_data_o.digest_word = dig_q[oidx_q];
  assign out_data_o.last_word   = (oidx_q == 3'd7);

endmodule
`default_nettype wire

### rtl/sm3_hash_engine_core.sv
// SM3 hash engine top level. A block runs its 64 rounds (one round a cycle in
// the shared round unit), then one fold; each message word is buffered as it
// is taken. End of message adds 3 to 18 padding words, maybe a second block,
// then eight digest words, one per cycle while out_stall is low. Reset restores
// the standard IV and idles.
`default_nettype none
module sm3_hash_engine_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sm3_pkg::in_word_t  in_data_i,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sm3_pkg::out_word_t      out_data_o,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import sm3_pkg::*;

  logic [255:0] iv_q;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= IvReset;
    end else if (cfg_valid && cfg_ready) begin
      iv_q[255 - 32*cfg_index_i -: 32] <= cfg_data_i;
    end
  end

  sm3_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .out_valid, .out_stall, .status_i(status), .cmd_o(cmd)
  );

  sm3_datapath u_dp (
    .clk_i, .rst_ni, .iv_i(iv_q), .in_data_i, .cmd_i(cmd),
    .status_o(status), .out_data_o
  );

  // Rounds and digest output never overlap.
  a_round_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.round && out_valid)) else $error("round during output");
  // Input is never taken while rounds run.
  a_no_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round |-> in_stall) else $error("input during rounds");
  // A fold always follows the last round.
  a_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.round && status.round_last) |=> cmd.fold) else $error("missing fold");

endmodule
`default_nettype wire

### test/tb_sm3_hash_engine_core.sv
// Self-checking testbench for the SM3 hash engine core: random and directed
// messages, IV reprogramming, random valid/stall bursts. Depends on sm3_pkg.
`default_nettype none
module tb_sm3_hash_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sm3_pkg::*;

  class digest_scoreboard;
    logic [31:0] iv_regs [8];
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    int unsigned widx;
    logic [63:0] bit_len;
    bit started;
    out_word_t pending [$];
    int errors;

    function void reset_state();
      for (int i = 0; i < 8; i++) begin
        iv_regs[i] = IvReset[255 - 32*i -: 32];
        chain[i] = iv_regs[i];
      end
      for (int i = 0; i < 16; i++) blk[i] = '0;
      widx = 0;
      bit_len = '0;
      started = 0;
      errors = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] v [8];
      logic [31:0] wj, wj1, tc, a12, ss1, ss2, ff, gg, tt1, tt2, x;
      int k;
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int j = 0; j < 64; j++) begin
        if (j >= 12) begin
          k = j + 4;
          x = blk[(k-16)&15] ^ blk[(k-9)&15] ^ rol(blk[(k-3)&15], 15);
          blk[k&15] = (x ^ rol(x, 15) ^ rol(x, 23)) ^ rol(blk[(k-13)&15], 7)
                      ^ blk[(k-6)&15];
        end
        wj = blk[j&15];
        wj1 = wj ^ blk[(j+4)&15];
        tc = (j < 16) ? TLow : THigh;
        a12 = rol(v[0], 12);
        ss1 = rol(a12 + v[4] + rol(tc, j), 7);
        ss2 = ss1 ^ a12;
        if (j < 16) begin
          ff = v[0] ^ v[1] ^ v[2];
          gg = v[4] ^ v[5] ^ v[6];
        end else begin
          ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
          gg = (v[4] & v[5]) | (~v[4] & v[6]);
        end
        tt1 = ff + v[3] + ss2 + wj1;
        tt2 = gg + v[7] + ss1 + wj;
        v[3] = v[2]; v[2] = rol(v[1], 9); v[1] = v[0]; v[0] = tt1;
        v[7] = v[6]; v[6] = rol(v[5], 19); v[5] = v[4];
        v[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      end
      for (int i = 0; i < 8; i++) chain[i] ^= v[i];
    endfunction

    function void buffer_word(logic [31:0] w);
      if (!started) begin
        for (int i = 0; i < 8; i++) chain[i] = iv_regs[i];
        started = 1;
      end
      blk[widx] = w;
      widx = (widx + 1) % 16;
      if (widx == 0) compress();
    endfunction

    function void note_input(in_word_t it);
      int bc;
      logic [31:0] pw;
      out_word_t o;
      if (!it.end_of_message) begin
        buffer_word(it.message_word);
        bit_len += 32;
        return;
      end
      bc = (it.byte_count > 4) ? 4 : it.byte_count;
      bit_len += 8 * bc;
      if (bc == 4) begin
        buffer_word(it.message_word);
        pw = 32'h8000_0000;
      end else begin
        pw = (bc == 0) ? 32'h0 : (it.message_word & (32'hFFFF_FFFF << (32 - 8*bc)));
        pw |= PadByte << (24 - 8*bc);
      end
      buffer_word(pw);
      if (widx > 14) buffer_word('0);
      while (widx < 14) buffer_word('0);
      buffer_word(bit_len[63:32]);
      buffer_word(bit_len[31:0]);
      for (int i = 0; i < 8; i++) begin
        o.digest_word = chain[i];
        o.last_word = (i == 7);
        pending.push_back(o);
      end
      bit_len = '0;
      started = 0;
      widx = 0;
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digest word %h", $realtime, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.digest_word !== exp_w.digest_word) begin
        $display("%0t: digest_word expected %h actual %h", $realtime,
                 exp_w.digest_word, got.digest_word);
        errors++;
      end
      if (got.last_word !== exp_w.last_word) begin
        $display("%0t: last_word expected %b actual %b", $realtime,
                 exp_w.last_word, got.last_word);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_data_i = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_data_o;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  digest_scoreboard sb;
  bit calm = 0;
  int idle_cycles = 0;
  int sent_words = 0;
  int stall_left = 0;

  always #5 clk_i = ~clk_i;

  sm3_hash_engine_core dut (.*);

  // Receiver: random stall bursts, checks every accepted word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_data_o);
    if (calm) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7);
      out_stall <= 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] w, logic [2:0] bc, logic eom);
    in_word_t it;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    it.message_word = w;
    it.byte_count = bc;
    it.end_of_message = eom;
    in_valid <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(it);
    sent_words++;
  endtask

  task automatic send_message(int nwords, int mode);
    logic [31:0] w;
    for (int i = 0; i < nwords; i++) begin
      w = (mode == 1) ? 32'hFFFF_FFFF : (mode == 2) ? 32'h0 : $urandom;
      send_word(w, 3'($urandom_range(0, 7)), 0);
    end
    w = (mode == 1) ? 32'hFFFF_FFFF : (mode == 2) ? 32'h0 : $urandom;
    send_word(w, 3'($urandom_range(0, 7)), 1);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_iv(int idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index_i <= 3'(idx);
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.iv_regs[idx] = val;
  endtask

  task automatic send_final(int nfull, logic [31:0] w, logic [2:0] bc);
    for (int i = 0; i < nfull; i++) send_word($urandom, 3'd4, 0);
    send_word(w, bc, 1);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: empty message, final byte counts 0 to 5 and 7, padding that
    // spills into an extra block, extreme words, saturated byte counts.
    send_final(0, 32'h0, 3'd0);
    send_final(0, 32'h6162_6300, 3'd3);
    send_final(0, 32'hFFFF_FFFF, 3'd4);
    send_final(1, 32'hFFFF_FFFF, 3'd1);
    send_final(1, 32'h1234_5678, 3'd2);
    send_final(13, 32'hFFFF_FFFF, 3'd7);
    send_final(14, 32'hA5A5_A5A5, 3'd5);
    send_message(2, 1);
    send_message(2, 2);
    drain();
    for (int i = 0; i < 8; i++) write_iv(i, 32'h0);
    cfg_valid <= 0;
    send_final(0, 32'h0, 3'd0);
    send_message(3, 0);
    drain();
    for (int i = 0; i < 8; i++) write_iv(i, 32'hFFFF_FFFF);
    cfg_valid <= 0;
    send_message(15, 0);
    drain();
    while (sent_words < 470) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        for (int i = 0; i < 8; i++) write_iv(i, $urandom);
        cfg_valid <= 0;
      end
      if (sent_words > 400) calm = 1;
      send_message(($urandom_range(0, 9) == 0) ? $urandom_range(14, 40)
                                                : $urandom_range(0, 15), 0);
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

### sm3_hash_engine_core.f
rtl/sm3_pkg.sv
rtl/sm3_ctrl.sv
rtl/sm3_datapath.sv
rtl/sm3_hash_engine_core.sv
test/tb_sm3_hash_engine_core.sv
